@@ sv/crcg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package crcg_pkg;

    localparam int MAX_DISTANCE = 8;
    localparam int MAX_SIDE     = 1024;

    localparam int COORD_W = 10;
    localparam int SIDE_W  = 11;
    localparam int DIST_W  = 4;
    localparam int INDEX_W = 20;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Signed offset wide enough for -MAX_DISTANCE..+MAX_DISTANCE.
    localparam int OFS_W   = $clog2(MAX_DISTANCE) + 2;
    // Signed candidate coordinate: center plus offset with a sign bit.
    localparam int NX_W    = COORD_W + 2;

    localparam logic [SIDE_W-1:0] SIDE_LIMIT  = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_RESET  = SIDE_W'(64);
    localparam logic [DIST_W-1:0] DIST_LIMIT  = DIST_W'(MAX_DISTANCE);

    typedef enum logic
    {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } crcg_reg_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } crcg_state_t;

    typedef struct packed
    {
        logic load;
        logic step;
        logic flush;
    } crcg_cmd_t;

    typedef struct packed
    {
        logic dist_zero;
        logic cand_valid;
        logic pend_valid;
        logic out_free;
        logic walk_done;
    } crcg_status_t;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        clamp_side = (v > SIDE_LIMIT) ? SIDE_LIMIT : v;
    endfunction

endpackage

`default_nettype wire

@@ sv/crcg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crcg_regs
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [crcg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [crcg_pkg::DATA_W-1:0] pwdata,
    output logic      [crcg_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output logic      [crcg_pkg::SIDE_W-1:0] grid_width,
    output logic      [crcg_pkg::SIDE_W-1:0] grid_height
);
    import crcg_pkg::*;

    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic              wr_en;
    crcg_reg_t         sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = crcg_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIDE_RESET;
            height_reg <= SIDE_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_GRID_WIDTH:  width_reg  <= pwdata[SIDE_W-1:0];
                REG_GRID_HEIGHT: height_reg <= pwdata[SIDE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_GRID_WIDTH:  prdata = DATA_W'(width_reg);
            REG_GRID_HEIGHT: prdata = DATA_W'(height_reg);
            default:         prdata = '0;
        endcase
    end

    assign grid_width  = width_reg;
    assign grid_height = height_reg;

endmodule

`default_nettype wire

@@ sv/crcg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crcg_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire crcg_pkg::crcg_status_t status,
    output crcg_pkg::crcg_cmd_t        cmd
);
    import crcg_pkg::*;

    crcg_state_t state_reg;
    crcg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    // A zero-distance ring is taken and dropped at once.
                    if (!status.dist_zero)
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // Hold the walker only when a found cell has nowhere to go.
                cmd.step = !(status.cand_valid && status.pend_valid && !status.out_free);
                if (cmd.step && status.walk_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE))
        else $error("input taken while a ring is in progress");

    a_flush_has_cell: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> (status.pend_valid && status.out_free))
        else $error("flush without a pending cell or free output");

    a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && state_next == ST_FLUSH) |-> status.walk_done)
        else $error("walk left before the last offset");

endmodule

`default_nettype wire

@@ sv/crcg_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crcg_dp
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire crcg_pkg::crcg_cmd_t          cmd,
    output crcg_pkg::crcg_status_t            status,
    input  wire logic [crcg_pkg::COORD_W-1:0] center_x,
    input  wire logic [crcg_pkg::COORD_W-1:0] center_y,
    input  wire logic [crcg_pkg::DIST_W-1:0]  ring_distance,
    input  wire logic [crcg_pkg::SIDE_W-1:0]  grid_width,
    input  wire logic [crcg_pkg::SIDE_W-1:0]  grid_height,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [crcg_pkg::COORD_W-1:0] cell_x,
    output logic      [crcg_pkg::COORD_W-1:0] cell_y,
    output logic      [crcg_pkg::INDEX_W-1:0] cell_index,
    output logic                              last_cell
);
    import crcg_pkg::*;

    logic [COORD_W-1:0]       cx_reg;
    logic [COORD_W-1:0]       cy_reg;
    logic [OFS_W-2:0]         d_reg;
    logic signed [OFS_W-1:0]  dx_reg;
    logic signed [OFS_W-1:0]  dx_next;
    logic signed [OFS_W-1:0]  dy_reg;
    logic signed [OFS_W-1:0]  dy_next;

    logic                     pend_valid_reg;
    logic [COORD_W-1:0]       pend_x_reg;
    logic [COORD_W-1:0]       pend_y_reg;
    logic [INDEX_W-1:0]       pend_index_reg;

    logic                     out_valid_reg;
    logic [COORD_W-1:0]       out_x_reg;
    logic [COORD_W-1:0]       out_y_reg;
    logic [INDEX_W-1:0]       out_index_reg;
    logic                     out_last_reg;

    logic [DIST_W-1:0]        d_sat;
    logic signed [OFS_W-1:0]  pos_d;
    logic signed [OFS_W-1:0]  neg_d;
    logic                     edge_row;
    logic                     walk_done;
    logic [NX_W-1:0]          nx;
    logic [NX_W-1:0]          ny;
    logic [SIDE_W-1:0]        w_lim;
    logic [SIDE_W-1:0]        h_lim;
    logic                     cand_valid;
    logic [COORD_W+SIDE_W-1:0] row_base;
    logic [INDEX_W-1:0]       cand_index;
    logic                     out_free;
    logic                     push_mid;

    assign d_sat  = (ring_distance > DIST_LIMIT) ? DIST_LIMIT : ring_distance;
    assign pos_d  = $signed({1'b0, d_reg});
    assign neg_d  = -pos_d;
    assign w_lim  = clamp_side(grid_width);
    assign h_lim  = clamp_side(grid_height);

    // Rows at the top and bottom of the ring are walked cell by cell; the
    // rows between them hold only their two end cells.
    assign edge_row  = (dy_reg == neg_d) || (dy_reg == pos_d);
    assign walk_done = (dy_reg == pos_d) && (dx_reg == pos_d);

    always_comb
    begin
        dx_next = dx_reg;
        dy_next = dy_reg;
        if (dx_reg == pos_d)
        begin
            dx_next = neg_d;
            dy_next = dy_reg + OFS_W'(1);
        end
        else if (edge_row)
        begin
            dx_next = dx_reg + OFS_W'(1);
        end
        else
        begin
            dx_next = pos_d;
        end
    end

    assign nx = {2'b00, cx_reg} + {{(NX_W-OFS_W){dx_reg[OFS_W-1]}}, dx_reg};
    assign ny = {2'b00, cy_reg} + {{(NX_W-OFS_W){dy_reg[OFS_W-1]}}, dy_reg};

    assign cand_valid = !nx[NX_W-1] && !ny[NX_W-1]
                        && (nx[SIDE_W-1:0] < w_lim) && (ny[SIDE_W-1:0] < h_lim);

    assign row_base   = ny[COORD_W-1:0] * w_lim;
    assign cand_index = row_base[INDEX_W-1:0] + INDEX_W'(nx[COORD_W-1:0]);

    assign out_free = !out_valid_reg || !out_stall;
    assign push_mid = cmd.step && cand_valid && pend_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            d_reg  <= (OFS_W-1)'(d_sat);
            dx_reg <= -$signed({1'b0, (OFS_W-1)'(d_sat)});
            dy_reg <= -$signed({1'b0, (OFS_W-1)'(d_sat)});
        end
        else if (cmd.step)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.step && cand_valid)
            begin
                pend_valid_reg <= 1'b1;
            end

            if (push_mid || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A cell is held until the next is found, so the last can be marked.
    always_ff @(posedge clk)
    begin
        if (cmd.step && cand_valid)
        begin
            pend_x_reg     <= nx[COORD_W-1:0];
            pend_y_reg     <= ny[COORD_W-1:0];
            pend_index_reg <= cand_index;
        end
        if (push_mid || cmd.flush)
        begin
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_index_reg <= pend_index_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    assign status.dist_zero  = (d_sat == '0);
    assign status.cand_valid = cand_valid;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;
    assign status.walk_done  = walk_done;

    assign out_valid  = out_valid_reg;
    assign cell_x     = out_x_reg;
    assign cell_y     = out_y_reg;
    assign cell_index = out_index_reg;
    assign last_cell  = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (push_mid || cmd.flush) |-> out_free)
        else $error("output register overwritten while stalled");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (dy_reg <= pos_d && dy_reg >= neg_d
                      && dx_reg <= pos_d && dx_reg >= neg_d))
        else $error("ring offset out of range");

    a_ring_cell: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (edge_row || dx_reg == pos_d || dx_reg == neg_d))
        else $error("walker visited a cell inside the ring");

endmodule

`default_nettype wire

@@ sv/chebyshev_ring_coordinate_generator.sv @@
// Each item is accepted in the idle state, walked over the 8*d ring positions
// (d the saturated ring distance) and closed by a flush step; d = 0 is only
// accepted. A cell reaches the output the cycle after the next one is found.
// The last cell reaches it the cycle after the flush step. The offset walker
// visits one ring position a cycle, and a stall downstream holds it.
// Reset sets grid_width and grid_height to 64 and idles the walker.
`timescale 1ns / 1ps
`default_nettype none

module chebyshev_ring_coordinate_generator
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [crcg_pkg::COORD_W-1:0] center_x,
    input  wire logic [crcg_pkg::COORD_W-1:0] center_y,
    input  wire logic [crcg_pkg::DIST_W-1:0]  ring_distance,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [crcg_pkg::COORD_W-1:0] cell_x,
    output logic      [crcg_pkg::COORD_W-1:0] cell_y,
    output logic      [crcg_pkg::INDEX_W-1:0] cell_index,
    output logic                              last_cell,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [crcg_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [crcg_pkg::DATA_W-1:0]  pwdata,
    output logic      [crcg_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);
    import crcg_pkg::*;

    logic [SIDE_W-1:0] grid_width;
    logic [SIDE_W-1:0] grid_height;
    crcg_cmd_t         cmd;
    crcg_status_t      status;

    crcg_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .grid_width  (grid_width),
        .grid_height (grid_height)
    );

    crcg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    crcg_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .center_x      (center_x),
        .center_y      (center_y),
        .ring_distance (ring_distance),
        .grid_width    (grid_width),
        .grid_height   (grid_height),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .cell_index    (cell_index),
        .last_cell     (last_cell)
    );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

import crcg_pkg::*;

typedef struct packed
{
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] idx;
    logic               last;
} ring_cell_t;

// Keeps a copy of the grid registers, expands each accepted center into the
// in-grid cells of its ring and holds them until the block emits them.
class ring_cell_tracker;
    ring_cell_t         cells_due[$];
    logic [SIDE_W-1:0]  grid_width  = SIDE_RESET;
    logic [SIDE_W-1:0]  grid_height = SIDE_RESET;
    int                 mismatches  = 0;

    function void set_reg(crcg_reg_t sel, logic [DATA_W-1:0] value);
        if (sel == REG_GRID_WIDTH)
        begin
            grid_width = value[SIDE_W-1:0];
        end
        else
        begin
            grid_height = value[SIDE_W-1:0];
        end
    endfunction

    function int pending();
        return cells_due.size();
    endfunction

    function void note_center(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                              logic [DIST_W-1:0] ring_d);
        int         d;
        int         w;
        int         h;
        int         nx;
        int         ny;
        int         first;
        ring_cell_t c;
        d = (ring_d > MAX_DISTANCE) ? MAX_DISTANCE : int'(ring_d);
        w = (grid_width > MAX_SIDE) ? MAX_SIDE : int'(grid_width);
        h = (grid_height > MAX_SIDE) ? MAX_SIDE : int'(grid_height);
        first = cells_due.size();
        if (d == 0)
        begin
            return;
        end
        for (int dy = -d; dy <= d; dy++)
        begin
            for (int dx = -d; dx <= d; dx++)
            begin
                // Only the border of the square belongs to the ring.
                if (dx != -d && dx != d && dy != -d && dy != d)
                begin
                    continue;
                end
                nx = int'(cx) + dx;
                ny = int'(cy) + dy;
                if (nx < 0 || ny < 0 || nx >= w || ny >= h)
                begin
                    continue;
                end
                c.x    = COORD_W'(nx);
                c.y    = COORD_W'(ny);
                c.idx  = INDEX_W'(ny * w + nx);
                c.last = 1'b0;
                cells_due = {cells_due, c};
            end
        end
        if (cells_due.size() > first)
        begin
            cells_due[cells_due.size() - 1].last = 1'b1;
        end
    endfunction

    function void check_cell(ring_cell_t got);
        ring_cell_t want;
        if (cells_due.size() == 0)
        begin
            if (mismatches < 10)
            begin
                $display("unexpected cell: x=%0d y=%0d index=%0d last=%0b",
                         got.x, got.y, got.idx, got.last);
            end
            mismatches++;
            return;
        end
        want = cells_due.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.idx !== want.idx ||
            got.last !== want.last)
        begin
            if (mismatches < 10)
            begin
                $display({"cell mismatch: expected x=%0d y=%0d index=%0d last=%0b,",
                          " got x=%0d y=%0d index=%0d last=%0b"},
                         want.x, want.y, want.idx, want.last,
                         got.x, got.y, got.idx, got.last);
            end
            mismatches++;
        end
    endfunction
endclass

module tb;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int QUIET_CYCLES    = 8 * MAX_DISTANCE + 16;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 15;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [COORD_W-1:0]   center_x      = '0;
    logic [COORD_W-1:0]   center_y      = '0;
    logic [DIST_W-1:0]    ring_distance = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic [INDEX_W-1:0]   cell_index;
    logic                 last_cell;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [ADDR_W-1:0]    paddr         = '0;
    logic [DATA_W-1:0]    pwdata        = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int unsigned          cycle_count   = 0;
    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    int                   phase_width  [NUM_PHASES] = '{1, 1024, 2047, 0, 17, 300};
    int                   phase_height [NUM_PHASES] = '{1, 1024, 5, 37, 2047, 1};
    ring_cell_tracker     rings         = new();

    chebyshev_ring_coordinate_generator u_top (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("chebyshev_ring_coordinate_generator verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            rings.check_cell('{x: cell_x, y: cell_y, idx: cell_index, last: last_cell});
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 78; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 78; end
            default:       begin send_idle_pct = 25; stall_pct = 25; end
        endcase
    endtask

    task automatic send_center(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                               input logic [DIST_W-1:0] ring_d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        center_x      <= cx;
        center_y      <= cy;
        ring_distance <= ring_d;
        do @(posedge clk); while (in_stall);
        rings.note_center(cx, cy, ring_d);
    endtask

    // Most centers land on or just beside the grid so that rings are partly
    // clipped; the rest are drawn over the whole field range.
    task automatic send_random_center();
        int w_lim;
        int h_lim;
        w_lim = rings.grid_width + MAX_DISTANCE;
        h_lim = rings.grid_height + MAX_DISTANCE;
        if (w_lim > 1023) w_lim = 1023;
        if (h_lim > 1023) h_lim = 1023;
        if ($urandom_range(99) < 75)
        begin
            send_center(COORD_W'($urandom_range(0, w_lim)), COORD_W'($urandom_range(0, h_lim)),
                        DIST_W'($urandom_range(1, MAX_DISTANCE)));
        end
        else
        begin
            send_center(COORD_W'($urandom), COORD_W'($urandom), DIST_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (rings.pending() != 0);
    endtask

    // Rings that fall off the grid keep the walker busy without any output,
    // so give it time to finish before touching the registers.
    task automatic settle();
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input crcg_reg_t sel, input logic [SIDE_W-1:0] value);
        logic [DATA_W-1:0] word;
        word    = {DATA_W'($urandom)} << SIDE_W | DATA_W'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(sel));
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rings.set_reg(sel, word);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rings on the 64 by 64 grid left by reset.
        set_idling(IDLE_NONE);
        send_center(10, 10, 0);
        send_center(10, 10, 1);
        send_center(32, 32, 8);
        send_center(0, 0, 1);
        send_center(63, 63, 8);
        send_center(0, 0, 15);
        send_center(20, 20, 9);
        send_center(1023, 1023, 1);
        send_center(100, 5, 3);
        send_center(66, 10, 3);
        send_center(64, 64, 1);
        send_center(1023, 0, 8);
        send_center(0, 1023, 8);
        send_center(1023, 1023, 15);
        send_center(5, 63, 2);
        send_center(63, 0, 4);
        send_center(10'h2AA, 10'h155, 4'hA);
        send_center(10'h155, 10'h2AA, 4'h5);
        send_center(31, 40, 7);
        send_center(60, 2, 6);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_reg(REG_GRID_WIDTH, SIDE_W'(phase_width[p]));
            write_reg(REG_GRID_HEIGHT, SIDE_W'(phase_height[p]));
            set_idling(idle_mode_t'(p % 4));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                begin
                    wait_drained();
                end
                send_random_center();
            end
        end

        settle();
        if (rings.mismatches == 0 && rings.pending() == 0)
        begin
            $display("chebyshev_ring_coordinate_generator verification clean");
        end
        else
        begin
            $display("chebyshev_ring_coordinate_generator verification failed");
        end
        $finish;
    end

endmodule
